// File: rtl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared constants, configuration type and helpers for the set-associative
// cache lookup with FIFO replacement.
// ----------------------------------------------------------------------------
package sacf_pkg;

    // Parameter defaults
    localparam int unsigned SETS_DEF      = 64;
    localparam int unsigned WAYS_DEF      = 8;
    localparam int unsigned ADDR_BITS_DEF = 32;

    // Fixed field widths
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned SET_OUT_W = 6;
    localparam int unsigned WAY_OUT_W = 3;
    localparam int unsigned LINE_W    = 4;
    localparam int unsigned SLOG_W    = 3;
    localparam int unsigned WCFG_W    = 4;

    // Largest set count exponent honored
    localparam logic [SLOG_W-1:0] SLOG_MAX = 3'd6;

    // Configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam logic [1:0] REG_LINE = 2'd0;
    localparam logic [1:0] REG_SETS = 2'd1;
    localparam logic [1:0] REG_WAYS = 2'd2;

    localparam logic [LINE_W-1:0] LINE_RST = 4'd4;
    localparam logic [SLOG_W-1:0] SLOG_RST = 3'd0;
    localparam logic [WCFG_W-1:0] WAYS_RST = 4'd1;

    // Request queue between front and back
    localparam int unsigned Q_DEPTH = 2;

    typedef struct packed {
        logic [LINE_W-1:0] line_log2;
        logic [SLOG_W-1:0] sets_log2;
        logic [WCFG_W-1:0] ways;
    } t_cfg;

    // Reduce a set number below 64 modulo the set count:
    // binary long reduction, one conditional subtract per bit.
    function automatic logic [SET_OUT_W-1:0] set_mod(
        input logic [SET_OUT_W-1:0] v,
        input int unsigned          sets
    );
        logic [SET_OUT_W-1:0] r;
        r = v;
        for (int k = SET_OUT_W - 1; k >= 0; k--) begin
            if ((32'(r)) >= (sets << k)) begin
                r = r - SET_OUT_W'(sets << k);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/sacf_front.sv
// ----------------------------------------------------------------------------
// sacf_front
// Accepts address requests, derives block number and set, and pushes
// them into the request queue.
// ----------------------------------------------------------------------------
module sacf_front #(
    parameter int unsigned SETS      = sacf_pkg::SETS_DEF,
    parameter int unsigned ADDR_BITS = sacf_pkg::ADDR_BITS_DEF,
    localparam int unsigned BLK_W    = (ADDR_BITS < 32) ? ADDR_BITS : 32,
    localparam int unsigned SIDX_W   = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                        i_valid,
    input  logic [sacf_pkg::ADDR_W-1:0] i_address,
    input  sacf_pkg::t_cfg              i_cfg,
    input  logic                        i_clearing,
    input  logic                        i_q_full,
    output logic                        o_stall,
    output logic                        o_push,
    output logic [BLK_W-1:0]            o_block,
    output logic [SIDX_W-1:0]           o_set
);

    logic [BLK_W-1:0]                   addr_w;
    logic [sacf_pkg::SLOG_W-1:0]        slog;
    logic [sacf_pkg::SET_OUT_W-1:0]     smask;
    logic [sacf_pkg::SET_OUT_W-1:0]     set_raw;
    logic [sacf_pkg::SET_OUT_W-1:0]     set6;

    // Handshake: hold off during the clearing pass or with a full queue
    assign o_stall = i_clearing | i_q_full;
    assign o_push  = i_valid & ~o_stall;

    // Block number from the used address bits
    assign addr_w  = i_address[BLK_W-1:0];
    assign o_block = addr_w >> i_cfg.line_log2;

    // Set number: mask by sets in use, then fold into the physical sets
    assign slog    = (i_cfg.sets_log2 > sacf_pkg::SLOG_MAX) ? sacf_pkg::SLOG_MAX
                                                            : i_cfg.sets_log2;
    assign smask   = sacf_pkg::SET_OUT_W'((7'd1 << slog) - 7'd1);
    assign set_raw = o_block[sacf_pkg::SET_OUT_W-1:0] & smask;
    assign set6    = sacf_pkg::set_mod(set_raw, SETS);
    assign o_set   = SIDX_W'(set6);

endmodule

// File: rtl/sacf_queue.sv
// ----------------------------------------------------------------------------
// sacf_queue
// Short request queue decoupling the classifying front from the lookup back.
// ----------------------------------------------------------------------------
module sacf_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned QP_W = (sacf_pkg::Q_DEPTH > 1) ? $clog2(sacf_pkg::Q_DEPTH) : 1;
    localparam int unsigned QC_W = $clog2(sacf_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [sacf_pkg::Q_DEPTH];
    logic [QP_W-1:0]  r_wp, n_wp;
    logic [QP_W-1:0]  r_rp, n_rp;
    logic [QC_W-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == QC_W'(sacf_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Pointer and fill tracking
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (32'(r_wp) == sacf_pkg::Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (32'(r_rp) == sacf_pkg::Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/sacf_back.sv
// ----------------------------------------------------------------------------
// sacf_back
// Lookup engine: reads the set row, compares the ways, fills on a miss
// with FIFO replacement and holds the result in an output register.
// ----------------------------------------------------------------------------
module sacf_back #(
    parameter int unsigned SETS    = sacf_pkg::SETS_DEF,
    parameter int unsigned WAYS    = sacf_pkg::WAYS_DEF,
    parameter int unsigned BLK_W   = 32,
    localparam int unsigned SIDX_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sacf_pkg::t_cfg                 i_cfg,
    input  logic                           i_q_valid,
    input  logic [BLK_W-1:0]               i_q_block,
    input  logic [SIDX_W-1:0]              i_q_set,
    output logic                           o_q_pop,
    output logic                           o_clearing,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [sacf_pkg::SET_OUT_W-1:0] o_set_index,
    output logic [sacf_pkg::WAY_OUT_W-1:0] o_way_index
);

    localparam int unsigned WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned WCNT_W = $clog2(WAYS + 1);
    localparam int unsigned VP_W   = WAYS + WIDX_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    // Row stores: block numbers per way, and valid bits with FIFO pointer
    logic [WAYS-1:0][BLK_W-1:0] r_tag_mem [SETS];
    logic [VP_W-1:0]            r_vp_mem  [SETS];
    logic [WAYS-1:0][BLK_W-1:0] r_tag_rd;
    logic [VP_W-1:0]            r_vp_rd;

    logic [1:0]        r_state, n_state;
    logic [SIDX_W-1:0] r_clr, n_clr;
    logic [BLK_W-1:0]  r_block;
    logic [SIDX_W-1:0] r_set;

    logic              r_out_valid;
    logic              r_hit;
    logic [SIDX_W-1:0] r_out_set;
    logic [WIDX_W-1:0] r_out_way;

    logic [SIDX_W-1:0] rd_addr;
    logic [WCNT_W-1:0] eff_ways;
    logic [WAYS-1:0]   vld;
    logic [WIDX_W-1:0] ptr;
    logic              hit;
    logic [WIDX_W-1:0] hit_way;
    logic [WIDX_W-1:0] fill_way;
    logic [WIDX_W-1:0] next_ptr;
    logic [WIDX_W-1:0] res_way;
    logic              out_free;
    logic              done;
    logic              tag_we;
    logic              vp_we;
    logic [SIDX_W-1:0] vp_wa;
    logic [VP_W-1:0]   vp_wd;

    // Ways in use, clamped to one through WAYS
    always_comb begin
        if (i_cfg.ways == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (32'(i_cfg.ways) > WAYS) begin
            eff_ways = WCNT_W'(WAYS);
        end else begin
            eff_ways = WCNT_W'(i_cfg.ways);
        end
    end

    assign vld = r_vp_rd[VP_W-1:WIDX_W];
    assign ptr = r_vp_rd[WIDX_W-1:0];

    // Way compare, lowest matching way wins
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld[w] && (r_tag_rd[w] == r_block) && (w < int'(eff_ways))) begin
                hit     = 1'b1;
                hit_way = WIDX_W'(w);
            end
        end
    end

    // FIFO victim and pointer advance
    always_comb begin
        fill_way = (32'(ptr) >= 32'(eff_ways)) ? '0 : ptr;
        next_ptr = (32'(fill_way) + 1 == 32'(eff_ways)) ? '0 : fill_way + 1'b1;
    end

    assign res_way  = hit ? hit_way : fill_way;
    assign out_free = ~r_out_valid | ~i_stall;
    assign done     = (r_state == ST_LOOK) && out_free;

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign rd_addr    = (r_state == ST_LOOK) ? r_set : i_q_set;

    // Write-back: fill on miss, clear rows after reset
    assign tag_we = done & ~hit;
    assign vp_we  = o_clearing | (done & ~hit);
    assign vp_wa  = o_clearing ? r_clr : r_set;
    assign vp_wd  = o_clearing ? '0
                  : {vld | (WAYS'(1) << fill_way), next_ptr};

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == SETS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Capture the popped request
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_block <= i_q_block;
            r_set   <= i_q_set;
        end
    end

    // Block number store
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[r_set][fill_way] <= r_block;
        end
        r_tag_rd <= r_tag_mem[rd_addr];
    end

    // Valid and pointer store
    always_ff @(posedge i_clk) begin
        if (vp_we) begin
            r_vp_mem[vp_wa] <= vp_wd;
        end
        r_vp_rd <= r_vp_mem[rd_addr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_hit     <= hit;
            r_out_set <= r_set;
            r_out_way <= res_way;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_hit;
    assign o_set_index = sacf_pkg::SET_OUT_W'(r_out_set);
    assign o_way_index = sacf_pkg::WAY_OUT_W'(r_out_way);

endmodule

// File: rtl/set_assoc_cache_fifo_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup
// Set-associative cache directory lookup with FIFO replacement per set.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_address
//   result    out        o_valid / i_stall   o_hit, o_set_index, o_way_index
//   config    in         APB psel/penable    line_bytes_log2, sets_log2,
//                                            ways_in_use at 0x0, 0x4, 0x8
//
// In the lookup engine each request goes through a set row read from the
// synchronous row stores, then compare, write back and result register; the
// engine pops the next request only after that result is registered.
// After reset a clearing pass over all SETS rows zeroes valid bits and FIFO
// pointers with o_stall high. While a result is stalled the engine holds in
// its compare cycle and the two-entry request queue accepts until full.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup #(
    parameter int unsigned SETS      = sacf_pkg::SETS_DEF,
    parameter int unsigned WAYS      = sacf_pkg::WAYS_DEF,
    parameter int unsigned ADDR_BITS = sacf_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sacf_pkg::ADDR_W-1:0]     i_address,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic [sacf_pkg::SET_OUT_W-1:0]  o_set_index,
    output logic [sacf_pkg::WAY_OUT_W-1:0]  o_way_index,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sacf_pkg::PADDR_W-1:0]    paddr,
    input  logic [sacf_pkg::PDATA_W-1:0]    pwdata,
    output logic [sacf_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int unsigned BLK_W  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int unsigned SIDX_W = (SETS > 1) ? $clog2(SETS) : 1;

    logic [sacf_pkg::LINE_W-1:0] r_line;
    logic [sacf_pkg::SLOG_W-1:0] r_slog;
    logic [sacf_pkg::WCFG_W-1:0] r_ways;
    sacf_pkg::t_cfg              cfg;
    logic                        cfg_we;

    logic                        clearing;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        push;
    logic [BLK_W-1:0]            f_block;
    logic [SIDX_W-1:0]           f_set;
    logic [BLK_W+SIDX_W-1:0]     q_data;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= sacf_pkg::LINE_RST;
            r_slog <= sacf_pkg::SLOG_RST;
            r_ways <= sacf_pkg::WAYS_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                sacf_pkg::REG_LINE: r_line <= pwdata[sacf_pkg::LINE_W-1:0];
                sacf_pkg::REG_SETS: r_slog <= pwdata[sacf_pkg::SLOG_W-1:0];
                sacf_pkg::REG_WAYS: r_ways <= pwdata[sacf_pkg::WCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            sacf_pkg::REG_LINE: prdata = sacf_pkg::PDATA_W'(r_line);
            sacf_pkg::REG_SETS: prdata = sacf_pkg::PDATA_W'(r_slog);
            sacf_pkg::REG_WAYS: prdata = sacf_pkg::PDATA_W'(r_ways);
            default:            prdata = '0;
        endcase
    end

    assign cfg.line_log2 = r_line;
    assign cfg.sets_log2 = r_slog;
    assign cfg.ways      = r_ways;

    // Front: accept and classify
    sacf_front #(
        .SETS      (SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_valid    (i_valid),
        .i_address  (i_address),
        .i_cfg      (cfg),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_block    (f_block),
        .o_set      (f_set)
    );

    // Request queue
    sacf_queue #(
        .WIDTH (BLK_W + SIDX_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_block, f_set}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back: lookup, replacement and result
    sacf_back #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .BLK_W (BLK_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_block   (q_data[BLK_W+SIDX_W-1:SIDX_W]),
        .i_q_set     (q_data[SIDX_W-1:0]),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_set_index (o_set_index),
        .o_way_index (o_way_index)
    );

endmodule
